@@ src/csba_pkg.sv @@
// Shared types and constants for the contiguous slot bitmap allocator.
`timescale 1ns / 1ps

package csba_pkg;

    // Number of slots in the map; a power of two from 16 to 256.
    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    localparam logic [SLOT_W-1:0] LAST_SLOT      = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [7:0]        MAX_REGION_END = 8'(SLOT_COUNT - 2);
    localparam logic [7:0]        FAIL_SLOT      = 8'hFF;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] span_lo;
        logic [7:0] span_hi;
        logic [7:0] run_length;
        logic [7:0] free_base;
    } t_in_item;

    typedef struct packed {
        logic [7:0] start_slot;
        logic [1:0] status;
    } t_out_item;

    // Command to a map cell: shift the ring, and optionally overwrite the
    // bit entering the cell.
    typedef struct packed {
        logic shift;
        logic wr_en;
        logic wr_val;
    } t_ring_cmd;

endpackage

@@ src/csba_cell.sv @@
// One occupancy cell of the slot ring: holds one slot's busy bit.
`timescale 1ns / 1ps

module csba_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csba_pkg::t_ring_cmd i_cmd,
    input  logic                i_d,
    output logic                o_q
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_cmd.shift) begin
            n_bit = i_cmd.wr_en ? i_cmd.wr_val : i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_q = r_bit;

endmodule

@@ src/csba_ctrl.sv @@
// Sequencer: examines the slot at the ring head, scans, marks, frees, reports.
`timescale 1ns / 1ps

module csba_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  csba_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output csba_pkg::t_out_item         o_out_data,
    input  logic                        i_head_bit,
    output csba_pkg::t_ring_cmd         o_ring_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_HOLD
    } t_state;

    t_state                        r_state;
    logic [csba_pkg::SLOT_W-1:0]   r_k;
    logic [7:0]                    r_rstart;
    logic [7:0]                    r_rend;
    logic [7:0]                    r_len;
    logic [7:0]                    r_first;
    logic [7:0]                    r_run;
    logic                          r_found;
    logic [7:0]                    r_fstart;
    logic [7:0]                    r_fend;
    csba_pkg::t_out_item           r_res;
    logic                          r_out_valid;
    csba_pkg::t_out_item           r_out_data;

    logic                          bad_arg;
    logic [8:0]                    region_len;
    logic [7:0]                    k8;
    logic [csba_pkg::SLOT_W-1:0]   free_dist;
    logic                          in_region;
    logic [7:0]                    run_inc;
    logic                          pass_end;
    logic                          out_free;

    assign region_len = {1'b0, i_in_data.span_hi} - {1'b0, i_in_data.span_lo} + 9'd1;
    assign bad_arg    = (i_in_data.span_hi > csba_pkg::MAX_REGION_END) ||
                        (i_in_data.run_length == 8'd0) ||
                        (i_in_data.span_hi < i_in_data.span_lo) ||
                        (region_len < {1'b0, i_in_data.run_length});

    assign k8        = 8'(r_k);
    assign free_dist = r_k - r_first[csba_pkg::SLOT_W-1:0];
    assign in_region = (k8 >= r_rstart) && (k8 <= r_rend);
    assign run_inc   = r_run + 8'd1;
    assign pass_end  = (r_k == csba_pkg::LAST_SLOT);
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_ring_cmd = '0;
        case (r_state)
            S_SCAN: begin
                o_ring_cmd.shift = 1'b1;
            end
            S_MARK: begin
                o_ring_cmd.shift  = 1'b1;
                o_ring_cmd.wr_en  = (k8 >= r_fstart) && (k8 <= r_fend);
                o_ring_cmd.wr_val = 1'b1;
            end
            S_FREE: begin
                o_ring_cmd.shift  = 1'b1;
                o_ring_cmd.wr_en  = 8'(free_dist) < r_len;
                o_ring_cmd.wr_val = 1'b0;
            end
            default: begin
                o_ring_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_run       <= 8'd0;
        end else begin
            // in S_HOLD the output register is reloaded below instead
            if (r_out_valid && i_out_ready && r_state != S_HOLD) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rstart <= i_in_data.span_lo;
                        r_rend   <= i_in_data.span_hi;
                        r_len    <= i_in_data.run_length;
                        r_first  <= i_in_data.free_base;
                        r_k      <= '0;
                        r_run    <= 8'd0;
                        r_found  <= 1'b0;
                        if (i_in_data.kind == csba_pkg::KIND_FREE) begin
                            r_state <= S_FREE;
                        end else if (bad_arg) begin
                            r_res   <= '{start_slot: csba_pkg::FAIL_SLOT,
                                         status: csba_pkg::ST_BAD};
                            r_state <= S_HOLD;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_k <= r_k + 1'b1;
                    if (in_region && !r_found) begin
                        if (i_head_bit) begin
                            r_run <= 8'd0;
                        end else begin
                            r_run <= run_inc;
                            if (run_inc == r_len) begin
                                r_found  <= 1'b1;
                                r_fstart <= k8 - r_len + 8'd1;
                                r_fend   <= k8;
                            end
                        end
                    end
                    if (pass_end) begin
                        // the last slot is never inside a valid region
                        if (r_found) begin
                            r_state <= S_MARK;
                        end else begin
                            r_res   <= '{start_slot: csba_pkg::FAIL_SLOT,
                                         status: csba_pkg::ST_FULL};
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_MARK: begin
                    r_k <= r_k + 1'b1;
                    if (pass_end) begin
                        r_res   <= '{start_slot: r_fstart, status: csba_pkg::ST_OK};
                        r_state <= S_HOLD;
                    end
                end
                S_FREE: begin
                    r_k <= r_k + 1'b1;
                    if (pass_end) begin
                        r_res   <= '{start_slot: csba_pkg::FAIL_SLOT,
                                     status: csba_pkg::ST_OK};
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // wait for the output register to drain
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ src/contiguous_slot_bitmap_allocator_core.sv @@
// Top level of the contiguous slot bitmap allocator: slot ring and sequencer.
`timescale 1ns / 1ps

// First-fit allocator over a map of SLOT_COUNT slots, one busy bit per cell, all free after
// reset (no clearing pass). The cells form a ring that rotates one slot per cycle while a
// pass is in work, past a single head examiner, so every pass visits all SLOT_COUNT slots. A
// free transaction takes one pass; an allocate with bad arguments is answered without a pass;
// an allocate that finds no fitting run takes one pass; a successful allocate scans in one
// pass and marks the run in a second. One transaction is in work at a time; the result waits
// in an output register, and a new input transaction is taken while it waits.
module contiguous_slot_bitmap_allocator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csba_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csba_pkg::t_out_item o_out_data
);

    logic [csba_pkg::SLOT_COUNT-1:0] ring_q;
    csba_pkg::t_ring_cmd             ring_cmd;
    csba_pkg::t_ring_cmd             tail_cmd;
    csba_pkg::t_ring_cmd             body_cmd;

    assign tail_cmd = ring_cmd;
    assign body_cmd = '{shift: ring_cmd.shift, wr_en: 1'b0, wr_val: 1'b0};

    // Slot at cell 0 is the head; it re-enters at the tail, possibly rewritten.
    genvar g;
    generate
        for (g = 0; g < csba_pkg::SLOT_COUNT; g++) begin : g_cell
            if (g == csba_pkg::SLOT_COUNT - 1) begin : g_tail
                csba_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_cmd   (tail_cmd),
                    .i_d     (ring_q[0]),
                    .o_q     (ring_q[g])
                );
            end else begin : g_body
                csba_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_cmd   (body_cmd),
                    .i_d     (ring_q[g+1]),
                    .o_q     (ring_q[g])
                );
            end
        end
    endgenerate

    csba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_head_bit  (ring_q[0]),
        .o_ring_cmd  (ring_cmd)
    );

endmodule

@@ src/csba_checker.sv @@
// Port-level checks for the contiguous slot bitmap allocator, bound to the top level.
`timescale 1ns / 1ps

module csba_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input csba_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input csba_pkg::t_out_item o_out_data
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == csba_pkg::ST_OK ||
                         o_out_data.status == csba_pkg::ST_BAD ||
                         o_out_data.status == csba_pkg::ST_FULL))
        else $error("undefined status code");

    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != csba_pkg::ST_OK) |->
        (o_out_data.start_slot == csba_pkg::FAIL_SLOT))
        else $error("failed transaction without failure slot");

    // one transaction in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while busy");

endmodule

bind contiguous_slot_bitmap_allocator_core csba_checker u_csba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
